// ----- rtl/grfe_pkg.sv -----
// ----------------------------------------------------------------------------
// grfe_pkg
// shared types, codes and helpers for the rmc field extractor
// ----------------------------------------------------------------------------
package grfe_pkg;

    localparam int FIELD_CHARS_DEF  = 16;
    localparam int BUFFER_BYTES_DEF = 128;

    localparam logic [3:0] MIN_COORD_LEN_RST = 4'd5;
    localparam logic [3:0] FIELD_IDX_MAX     = 4'd15;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // field codes on the result words
    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_TIME = 3'd1;
    localparam logic [2:0] CODE_LAT  = 3'd2;
    localparam logic [2:0] CODE_LON  = 3'd3;
    localparam logic [2:0] CODE_SPD  = 3'd4;
    localparam logic [2:0] CODE_DATE = 3'd5;

    // comma counts that open the fields of interest
    localparam logic [3:0] FIDX_TIME = 4'd1;
    localparam logic [3:0] FIDX_LAT  = 4'd3;
    localparam logic [3:0] FIDX_LON  = 4'd5;
    localparam logic [3:0] FIDX_SPD  = 4'd7;
    localparam logic [3:0] FIDX_DATE = 4'd9;

    typedef struct packed {
        logic       write_valid;
        logic [2:0] field_code;
        logic [3:0] position;
        logic [7:0] char_out;
        logic       overflow;
        logic       detect;
        logic       run_last;
    } result_t;

    function automatic logic [2:0] code_of(input logic [3:0] fidx);
        logic [2:0] code;
        case (fidx)
            FIDX_TIME: code = CODE_TIME;
            FIDX_LAT:  code = CODE_LAT;
            FIDX_LON:  code = CODE_LON;
            FIDX_SPD:  code = CODE_SPD;
            FIDX_DATE: code = CODE_DATE;
            default:   code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/grfe_core.sv -----
// ----------------------------------------------------------------------------
// grfe_core
// running field state and per-byte result generation (up to two words)
// ----------------------------------------------------------------------------
module grfe_core
    import grfe_pkg::*;
#(
    parameter int FIELD_CHARS  = FIELD_CHARS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    rx_byte,
    input  logic          last_byte,
    input  logic [3:0]    min_coord_len,
    output logic [1:0]    res_cnt,
    output result_t       res0,
    output result_t       res1
);

    localparam int POS_W   = $clog2(BUFFER_BYTES);
    localparam int POS_CAP = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;
    localparam int LIM_INT = (FIELD_CHARS > POS_CAP) ? POS_CAP + 1 : FIELD_CHARS;
    localparam logic [POS_W:0]   FIELD_LIM = LIM_INT[POS_W:0];
    localparam logic [POS_W-1:0] POS_MAX   = POS_CAP[POS_W-1:0];

    logic [3:0]       field_index_reg, field_index_next;
    logic [POS_W-1:0] char_pos_reg, char_pos_next;
    logic             dot_seen_reg, dot_seen_next;
    logic             detect_reg, detect_next;

    logic [2:0]       code;
    logic [POS_W-1:0] pos_adv;
    logic             is_coord;
    logic             is_data;
    logic [POS_W-1:0] min_ext;

    result_t          slot0, slot1;
    logic [1:0]       cnt;

    function automatic result_t make_word(input logic [2:0] c,
                                          input logic [POS_W-1:0] p,
                                          input logic [7:0] ch);
        result_t w;
        logic    fits;
        fits          = {1'b0, p} < FIELD_LIM;
        w.write_valid = fits;
        w.field_code  = c;
        w.position    = p[3:0];
        w.char_out    = ch;
        w.overflow    = ~fits;
        w.detect      = 1'b0;
        w.run_last    = 1'b0;
        return w;
    endfunction

    assign code     = code_of(field_index_reg);
    assign is_coord = (code == CODE_LAT) || (code == CODE_LON);
    assign is_data  = (code == CODE_LAT) || (code == CODE_LON) ||
                      (code == CODE_SPD) || (code == CODE_DATE);
    assign pos_adv  = (char_pos_reg < POS_MAX) ? char_pos_reg + 1'b1 : char_pos_reg;
    assign min_ext  = {{(POS_W-4){1'b0}}, min_coord_len};

    always_comb
    begin
        field_index_next = field_index_reg;
        char_pos_next    = char_pos_reg;
        dot_seen_next    = dot_seen_reg;
        detect_next      = detect_reg;
        slot0            = make_word(code, char_pos_reg, CHAR_NUL);
        slot1            = make_word(code, pos_adv, CHAR_NUL);
        cnt              = 2'd0;

        if (rx_byte == CHAR_COMMA)
        begin
            if (is_data)
            begin
                cnt = 2'd1;
                if (is_coord)
                    detect_next = ~(char_pos_reg < min_ext);
            end
            if (field_index_reg < FIELD_IDX_MAX)
                field_index_next = field_index_reg + 1'b1;
            char_pos_next = '0;
            dot_seen_next = 1'b0;
        end
        else
        begin
            if (code == CODE_TIME)
            begin
                // a dot ends the stored time string
                if (rx_byte == CHAR_DOT)
                begin
                    dot_seen_next = 1'b1;
                    cnt           = 2'd1;
                end
                else if (!dot_seen_reg)
                begin
                    slot0.char_out = rx_byte;
                    cnt            = 2'd1;
                end
                char_pos_next = pos_adv;
            end
            else if (is_data)
            begin
                slot0.char_out = rx_byte;
                cnt            = 2'd1;
                char_pos_next  = pos_adv;
            end

            // buffer end inside a data field closes the string
            if (last_byte && is_data)
            begin
                cnt = 2'd2;
                if (is_coord)
                    detect_next = ~(pos_adv < min_ext);
            end
        end

        if (last_byte)
        begin
            field_index_next = '0;
            char_pos_next    = '0;
            dot_seen_next    = 1'b0;
        end

        slot0.detect   = detect_next;
        slot1.detect   = detect_next;
        slot0.run_last = (cnt == 2'd1);
        slot1.run_last = 1'b1;
    end

    assign res_cnt = cnt;
    assign res0    = slot0;
    assign res1    = slot1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            char_pos_reg    <= '0;
            dot_seen_reg    <= 1'b0;
            detect_reg      <= 1'b0;
        end
        else if (fire)
        begin
            field_index_reg <= field_index_next;
            char_pos_reg    <= char_pos_next;
            dot_seen_reg    <= dot_seen_next;
            detect_reg      <= detect_next;
        end
    end

endmodule

// ----- rtl/grfe_out_buf.sv -----
// ----------------------------------------------------------------------------
// grfe_out_buf
// two-entry result register feeding the output channel
// ----------------------------------------------------------------------------
module grfe_out_buf
    import grfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [1:0] load_cnt,
    input  result_t    load0,
    input  result_t    load1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // empty after this cycle's pop
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign head      = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = load_cnt;
            slot0_next = load0;
            slot1_next = load1;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 1'b1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- rtl/gps_rmc_field_extractor_top.sv -----
// ----------------------------------------------------------------------------
// gps_rmc_field_extractor_top
// comma-counting field extractor for rmc-style position sentences
// ----------------------------------------------------------------------------
// Sentence bytes come in one word per cycle and are held in an input
// register; the field logic turns each byte into zero, one or two result
// words which land in a two-entry result register in front of the output
// channel. A byte is taken every cycle while the output side keeps up and
// passes the input register, then the result register, before its first
// result word shows. The only byte that gives two words is a final byte
// inside latitude, longitude, speed or date (its character plus the closing
// terminator); while the first of them drains, the input register holds the
// next byte. min_coord_len resets to 5 and must be written by the user through
// cfg_wen / cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module gps_rmc_field_extractor_top
    import grfe_pkg::*;
#(
    parameter int FIELD_CHARS  = FIELD_CHARS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wen,
    input  logic [3:0] cfg_wdata,
    // sentence bytes in
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    // result words out
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_valid,
    output logic [2:0] field_code,
    output logic [3:0] position,
    output logic [7:0] char_out,
    output logic       overflow,
    output logic       detect,
    output logic       run_last
);

    // configuration register
    logic [3:0] min_len_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // field logic to result register
    logic       room;
    logic       proc_fire;
    logic [1:0] res_cnt;
    result_t    res0, res1;
    result_t    head;

    // byte leaves the input register once the result register will be free
    assign proc_fire = in_vld_reg && room;
    assign in_ready  = !in_vld_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= MIN_COORD_LEN_RST;
        else if (cfg_wen)
            min_len_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_vld_reg <= 1'b1;
        else if (proc_fire)
            in_vld_reg <= 1'b0;
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
            in_last_reg <= last_byte;
        end
    end

    grfe_core #(
        .FIELD_CHARS  (FIELD_CHARS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (proc_fire),
        .rx_byte       (in_byte_reg),
        .last_byte     (in_last_reg),
        .min_coord_len (min_len_reg),
        .res_cnt       (res_cnt),
        .res0          (res0),
        .res1          (res1)
    );

    // a byte with no result still clears the input register, loading an
    // empty buffer
    grfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_fire),
        .load_cnt  (res_cnt),
        .load0     (res0),
        .load1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign write_valid = head.write_valid;
    assign field_code  = head.field_code;
    assign position    = head.position;
    assign char_out    = head.char_out;
    assign overflow    = head.overflow;
    assign detect      = head.detect;
    assign run_last    = head.run_last;

endmodule

// ----- tb/gps_rmc_field_extractor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_rmc_field_extractor_top_tb
// self-checking bench for the rmc field extractor
// ----------------------------------------------------------------------------
// Sentences go in as bytes over the input channel: a short hand-written set
// first, then random sentences, mostly well formed with random field content
// and lengths, some noise. A predictor class keeps its own copy of the field
// state and works out the stores each accepted byte should cause; every word
// leaving the block is compared field by field with the oldest one waiting.
// The run steps through several coordinate length thresholds, written while
// the block is idle. Both channels idle at random, and once the result side
// holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module gps_rmc_field_extractor_top_tb;
    import grfe_pkg::*;

    localparam int FIELD_CHARS  = FIELD_CHARS_DEF;
    localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
    // char position stops counting here inside a long field
    localparam int POS_LIMIT    = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;

    localparam int ITEMS        = 1250;   // random bytes to send
    localparam int PHASES       = 6;      // reset threshold plus five written ones
    localparam int DRAIN_CYCLES = 16;     // settle time once nothing is awaited
    localparam int LONG_HOLD    = 400;    // long receiver hold-off, in cycles
    localparam int STALL_LIMIT  = 4000;   // watchdog: cycles with no word moved

    typedef logic [7:0] byte_q_t [$];

    // ------------------------------------------------------------------------
    // predictor and store of expected words
    // ------------------------------------------------------------------------
    class rmc_store_predictor;
        logic [3:0] min_len;
        logic [3:0] field_idx;
        logic [7:0] char_pos;
        logic       dot_seen;
        logic       detect_flag;
        result_t    expected_stores [$];
        int         mismatches;
        int         words_seen;

        function new();
            min_len     = MIN_COORD_LEN_RST;
            field_idx   = '0;
            char_pos    = '0;
            dot_seen    = 1'b0;
            detect_flag = 1'b0;
            mismatches  = 0;
            words_seen  = 0;
        endfunction

        function logic [2:0] field_code_for(input logic [3:0] idx);
            case (idx)
                FIDX_TIME: return CODE_TIME;
                FIDX_LAT:  return CODE_LAT;
                FIDX_LON:  return CODE_LON;
                FIDX_SPD:  return CODE_SPD;
                FIDX_DATE: return CODE_DATE;
                default:   return CODE_NONE;
            endcase
        endfunction

        // store at the current position, dropped once past the field's room
        function result_t store_word(input logic [2:0] code, input logic [7:0] ch);
            result_t w;
            w.write_valid = (char_pos < FIELD_CHARS);
            w.field_code  = code;
            w.position    = char_pos[3:0];
            w.char_out    = ch;
            w.overflow    = !(char_pos < FIELD_CHARS);
            w.detect      = 1'b0;
            w.run_last    = 1'b0;
            return w;
        endfunction

        // coordinate length decides detect, the later field wins
        function void check_length(input logic [2:0] code);
            if (code == CODE_LAT || code == CODE_LON)
                detect_flag = (char_pos >= min_len);
        endfunction

        function void bump_position();
            if (char_pos < POS_LIMIT)
                char_pos++;
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            logic [2:0] code;
            result_t    run [$];
            code = field_code_for(field_idx);
            if (b == CHAR_COMMA) begin
                // comma closing time stores nothing
                if (code >= CODE_LAT) begin
                    run.push_back(store_word(code, CHAR_NUL));
                    check_length(code);
                end
                if (field_idx != FIELD_IDX_MAX)
                    field_idx++;
                char_pos = '0;
                dot_seen = 1'b0;
            end
            else begin
                if (code == CODE_TIME) begin
                    // fraction digits after the dot are dropped
                    if (b == CHAR_DOT) begin
                        dot_seen = 1'b1;
                        run.push_back(store_word(code, CHAR_NUL));
                    end
                    else if (!dot_seen) begin
                        run.push_back(store_word(code, b));
                    end
                    bump_position();
                end
                else if (code >= CODE_LAT) begin
                    run.push_back(store_word(code, b));
                    bump_position();
                end
                // end of buffer inside a stored field closes the string
                if (last && code >= CODE_LAT) begin
                    run.push_back(store_word(code, CHAR_NUL));
                    check_length(code);
                end
            end
            if (last) begin
                field_idx = '0;
                char_pos  = '0;
                dot_seen  = 1'b0;
            end
            foreach (run[k]) begin
                run[k].detect   = detect_flag;
                run[k].run_last = (k == run.size() - 1);
                expected_stores.push_back(run[k]);
            end
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch, word %0d: %s", $time, words_seen, msg);
            mismatches++;
        endtask

        task check_store(input result_t got);
            result_t want;
            if (expected_stores.size() == 0) begin
                report_mismatch($sformatf("arrived with nothing awaited, char_out %0h",
                                          got.char_out));
            end
            else begin
                want = expected_stores.pop_front();
                if (got.write_valid !== want.write_valid)
                    report_mismatch($sformatf("write_valid %b, expected %b",
                                              got.write_valid, want.write_valid));
                if (got.field_code !== want.field_code)
                    report_mismatch($sformatf("field_code %0h, expected %0h",
                                              got.field_code, want.field_code));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position %0h, expected %0h",
                                              got.position, want.position));
                if (got.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out %0h, expected %0h",
                                              got.char_out, want.char_out));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              got.overflow, want.overflow));
                if (got.detect !== want.detect)
                    report_mismatch($sformatf("detect %b, expected %b",
                                              got.detect, want.detect));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              got.run_last, want.run_last));
            end
            words_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_wen   = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = '0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       write_valid;
    logic [2:0] field_code;
    logic [3:0] position;
    logic [7:0] char_out;
    logic       overflow;
    logic       detect;
    logic       run_last;

    rmc_store_predictor store_pred = new();

    int bytes_sent   = 0;
    int quiet_cycles = 0;
    bit in_burst     = 1'b0;   // sender offers back to back
    bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off

    gps_rmc_field_extractor_top #(
        .FIELD_CHARS  (FIELD_CHARS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .write_valid (write_valid),
        .field_code  (field_code),
        .position    (position),
        .char_out    (char_out),
        .overflow    (overflow),
        .detect      (detect),
        .run_last    (run_last)
    );

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitors: both channels sampled on the edge that completes a handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles = quiet_cycles + 1;
            if (in_valid && in_ready) begin
                store_pred.note_byte(rx_byte, last_byte);
                quiet_cycles = 0;
            end
            if (out_valid && out_ready) begin
                store_pred.check_store({write_valid, field_code, position, char_out,
                                        overflow, detect, run_last});
                quiet_cycles = 0;
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, bursts with none, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        bit out_burst;
        out_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                // sender keeps offering meanwhile, so the block fills and stalls
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else begin
                if ($urandom_range(0, 39) == 0)
                    out_burst = !out_burst;
                gap = out_burst ? 0 : $urandom_range(0, 18);
                if (gap != 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one sentence, last_byte on its final word; valid stays up between
    // back-to-back words
    task automatic send_sentence(input byte_q_t seq);
        int gap;
        foreach (seq[k]) begin
            gap = in_burst ? 0 : $urandom_range(0, 18);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            rx_byte   <= seq[k];
            last_byte <= (k == seq.size() - 1);
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            bytes_sent++;
        end
    endtask

    // stop offering, wait for every awaited word, then let bytes that
    // store nothing clear the pipeline
    task automatic await_idle();
        in_valid <= 1'b0;
        while (store_pred.expected_stores.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_len(input logic [3:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        store_pred.min_len = value;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        byte_q_t    seq;
        string      directed_fields [10];
        logic [3:0] cfg_plan [PHASES-1];
        logic [7:0] ch;
        int         p, f, i, r, n_fields, len;

        // short latitude clears detect, longitude at the threshold sets it;
        // time has a dropped fraction, speed a closing comma, date ends the buffer
        directed_fields = '{"", "1.5", "", "ABCD", "", "12345", "", "7", "", "9"};
        cfg_plan = '{4'd0, 4'd15, 4'd3, 4'($urandom_range(0, 15)), 4'd9};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed sentences
        foreach (directed_fields[d]) begin
            if (d != 0)
                seq.push_back(CHAR_COMMA);
            for (i = 0; i < directed_fields[d].len(); i++)
                seq.push_back(directed_fields[d][i]);
        end
        send_sentence(seq);
        // byte extremes in the time field, buffer ending there adds nothing
        seq = '{CHAR_COMMA, 8'hFF, CHAR_NUL};
        send_sentence(seq);
        await_idle();

        // random phases, one threshold each
        for (p = 0; p < PHASES; p++) begin
            if (p != 0)
                write_min_len(cfg_plan[p-1]);
            if (p == 2)
                hold_off_req = 1'b1;
            while (bytes_sent < (p + 1) * ITEMS / PHASES) begin
                seq = {};
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    // noise, heavy on commas
                    len = $urandom_range(1, 30);
                    repeat (len)
                        seq.push_back(($urandom_range(0, 3) == 0) ? CHAR_COMMA
                                                                  : 8'($urandom_range(0, 255)));
                end
                else begin
                    // well formed: comma separated fields, sometimes enough
                    // of them to pin the field count at its top
                    n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20)
                                                           : $urandom_range(1, 12);
                    for (f = 0; f < n_fields; f++) begin
                        if (f != 0)
                            seq.push_back(CHAR_COMMA);
                        // mostly short, some past the field room, rarely past
                        // the position limit
                        r = $urandom_range(0, 99);
                        len = (r == 0) ? $urandom_range(120, 140) :
                              (r < 12) ? $urandom_range(14, 20)   : $urandom_range(0, 10);
                        repeat (len) begin
                            r = $urandom_range(0, 99);
                            if (r < 8)
                                ch = 8'($urandom_range(0, 255));
                            else if (r < ((f == FIDX_TIME) ? 30 : 12))
                                ch = CHAR_DOT;
                            else if (r < 45)
                                ch = 8'($urandom_range(8'h41, 8'h5A));
                            else
                                ch = 8'($urandom_range(8'h30, 8'h39));
                            seq.push_back(ch);
                        end
                    end
                    // now and then the buffer ends on a comma
                    if ($urandom_range(0, 7) == 0 || seq.size() == 0)
                        seq.push_back(CHAR_COMMA);
                end
                in_burst = ($urandom_range(0, 3) == 0);
                send_sentence(seq);
            end
            await_idle();
        end

        if (store_pred.expected_stores.size() != 0)
            store_pred.report_mismatch($sformatf("%0d words never arrived",
                                                 store_pred.expected_stores.size()));
        if (store_pred.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
